// ===== rtl/brc_pkg.sv =====
// ----------------------------------------------------------------------------
// brc_pkg
// Shared widths, types and helpers of the blit rectangle clipper.
// ----------------------------------------------------------------------------
package brc_pkg;

   // width of the destination position register, 8 to 32
   localparam int COORD_BITS = 16;
   localparam int FIELD_BITS = 16;
   // room for source offsets, lengths and cut amounts at full precision
   localparam int WIDE_BITS = ((COORD_BITS > FIELD_BITS) ? COORD_BITS : FIELD_BITS) + 4;

   localparam int REQ_DATA_BITS  = 8 * FIELD_BITS;
   localparam int REQ_USER_BITS  = 2;
   localparam int RSP_DATA_BITS  = 6 * FIELD_BITS;
   localparam int RSP_USER_BITS  = 1;
   localparam int CSR_INDEX_BITS = 2;

   typedef logic signed [WIDE_BITS-1:0]  brc_wide_type;
   typedef logic signed [COORD_BITS-1:0] brc_coord_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_CLIP_LEFT   = 2'd0,
      REG_CLIP_TOP    = 2'd1,
      REG_CLIP_WIDTH  = 2'd2,
      REG_CLIP_HEIGHT = 2'd3
   } brc_reg_type;

   typedef struct packed {
      logic                         src_given;
      logic signed [FIELD_BITS-1:0] src_pos;
      logic [FIELD_BITS-1:0]        src_len;
      logic [FIELD_BITS-1:0]        surf_len;
      brc_coord_type                dst_pos;
      logic signed [FIELD_BITS-1:0] clip_edge;
      logic [FIELD_BITS-1:0]        clip_len;
   } brc_axis_in_type;

   typedef struct packed {
      brc_wide_type  src_pos;
      brc_wide_type  len;
      brc_coord_type dst_pos;
   } brc_axis_out_type;

   function automatic brc_wide_type sext16(logic [FIELD_BITS-1:0] v);
      return brc_wide_type'({{(WIDE_BITS-FIELD_BITS){v[FIELD_BITS-1]}}, v});
   endfunction

   function automatic brc_wide_type zext16(logic [FIELD_BITS-1:0] v);
      return brc_wide_type'({{(WIDE_BITS-FIELD_BITS){1'b0}}, v});
   endfunction

   function automatic brc_wide_type sext_coord(brc_coord_type v);
      return brc_wide_type'({{(WIDE_BITS-COORD_BITS){v[COORD_BITS-1]}}, v});
   endfunction

   // wrap to the destination register width
   function automatic brc_coord_type wrap_coord(brc_wide_type v);
      return brc_coord_type'(v[COORD_BITS-1:0]);
   endfunction

endpackage

// ===== rtl/brc_axis_clip.sv =====
// ----------------------------------------------------------------------------
// brc_axis_clip
// Clips one axis: source to surface, then destination to the clip window.
// ----------------------------------------------------------------------------
module brc_axis_clip
   import brc_pkg::*;
(
   input  brc_axis_in_type  axis_in,
   output brc_axis_out_type axis_out
);

   brc_wide_type  edge_w;
   brc_wide_type  clip_w;
   brc_wide_type  sp_a;
   brc_wide_type  len_a;
   brc_wide_type  lim;
   brc_wide_type  d_lo;
   brc_wide_type  sp_b;
   brc_wide_type  len_b;
   brc_wide_type  d_hi;
   brc_wide_type  len_c;
   brc_coord_type dp_a;
   brc_coord_type dp_b;

   always_comb begin
      edge_w = sext16(axis_in.clip_edge);
      clip_w = zext16(axis_in.clip_len);
      dp_a   = axis_in.dst_pos;
      lim    = '0;

      if (axis_in.src_given) begin
         sp_a  = sext16(axis_in.src_pos);
         len_a = zext16(axis_in.src_len);
         // negative offset: trim length, push destination forward
         if (sp_a < 0) begin
            len_a = len_a + sp_a;
            dp_a  = wrap_coord(sext_coord(dp_a) - sp_a);
            sp_a  = '0;
         end
         lim = zext16(axis_in.surf_len) - sp_a;
         if (lim < len_a) begin
            len_a = lim;
         end
      end else begin
         sp_a  = '0;
         len_a = zext16(axis_in.surf_len);
      end

      // cut at the low clip edge
      d_lo  = edge_w - sext_coord(dp_a);
      sp_b  = sp_a;
      len_b = len_a;
      dp_b  = dp_a;
      if (d_lo > 0) begin
         len_b = len_a - d_lo;
         dp_b  = wrap_coord(sext_coord(dp_a) + d_lo);
         sp_b  = sp_a + d_lo;
      end

      // cut at the high clip edge
      d_hi  = sext_coord(dp_b) + len_b - edge_w - clip_w;
      len_c = len_b;
      if (d_hi > 0) begin
         len_c = len_b - d_hi;
      end

      axis_out.src_pos = sp_b;
      axis_out.len     = len_c;
      axis_out.dst_pos = dp_b;
   end

endmodule

// ===== rtl/blit_rect_clipper.sv =====
// ----------------------------------------------------------------------------
// blit_rect_clipper
// Clips blit requests to the source surface and the destination clip window.
// ----------------------------------------------------------------------------
// An accepted request loads the input register; its result loads the result
// register once that register is free, and is offered from there.
// The block takes one request per cycle; the input side stalls only while both
// registers are full and the result side holds off.
// Reset clears both pipeline valid bits and sets all clip registers to zero.
module blit_rect_clipper
   import brc_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   // request words
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // source_x, source_y, source_w, source_h, surface_width, surface_height,
   // dest_x, dest_y (16 bits each, lowest first)
   input  logic [REQ_DATA_BITS-1:0]  req_tdata,
   // source_rect_given, dest_given
   input  logic [REQ_USER_BITS-1:0]  req_tuser,
   // result words
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // clipped_src_x, clipped_src_y, clipped_w, clipped_h, clipped_dst_x,
   // clipped_dst_y (16 bits each, lowest first)
   output logic [RSP_DATA_BITS-1:0]  rsp_tdata,
   // visible
   output logic [RSP_USER_BITS-1:0]  rsp_tuser,
   // register writes
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [FIELD_BITS-1:0]     csr_data
);

   logic [FIELD_BITS-1:0] clip_left_ff;
   logic [FIELD_BITS-1:0] clip_top_ff;
   logic [FIELD_BITS-1:0] clip_width_ff;
   logic [FIELD_BITS-1:0] clip_height_ff;

   logic                     in_valid_ff;
   logic [REQ_DATA_BITS-1:0] in_data_ff;
   logic [REQ_USER_BITS-1:0] in_user_ff;
   logic                     out_valid_ff;
   logic [RSP_DATA_BITS-1:0] out_data_ff;
   logic [RSP_USER_BITS-1:0] out_user_ff;
   logic [RSP_DATA_BITS-1:0] out_data_in;
   logic [RSP_USER_BITS-1:0] out_user_in;

   logic             in_move;
   logic             req_take;
   brc_axis_in_type  x_in;
   brc_axis_in_type  y_in;
   brc_axis_out_type x_out;
   brc_axis_out_type y_out;
   logic             vis;
   brc_wide_type     dst_x_w;
   brc_wide_type     dst_y_w;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff   <= '0;
         clip_top_ff    <= '0;
         clip_width_ff  <= '0;
         clip_height_ff <= '0;
      end else if (csr_valid) begin
         unique case (brc_reg_type'(csr_index))
            REG_CLIP_LEFT:   clip_left_ff   <= csr_data;
            REG_CLIP_TOP:    clip_top_ff    <= csr_data;
            REG_CLIP_WIDTH:  clip_width_ff  <= csr_data;
            REG_CLIP_HEIGHT: clip_height_ff <= csr_data;
         endcase
      end
   end

   // advance the input register whenever the result register frees up
   assign in_move    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || in_move;
   assign req_take   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (!out_valid_ff || rsp_tready) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_tdata;
         in_user_ff <= req_tuser;
      end
      if (in_move) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   always_comb begin
      x_in.src_given = in_user_ff[0];
      x_in.src_pos   = in_data_ff[15:0];
      x_in.src_len   = in_data_ff[47:32];
      x_in.surf_len  = in_data_ff[79:64];
      x_in.dst_pos   = in_user_ff[1] ? wrap_coord(sext16(in_data_ff[111:96])) : '0;
      x_in.clip_edge = clip_left_ff;
      x_in.clip_len  = clip_width_ff;

      y_in.src_given = in_user_ff[0];
      y_in.src_pos   = in_data_ff[31:16];
      y_in.src_len   = in_data_ff[63:48];
      y_in.surf_len  = in_data_ff[95:80];
      y_in.dst_pos   = in_user_ff[1] ? wrap_coord(sext16(in_data_ff[127:112])) : '0;
      y_in.clip_edge = clip_top_ff;
      y_in.clip_len  = clip_height_ff;
   end

   brc_axis_clip u_clip_x (
      .axis_in  (x_in),
      .axis_out (x_out)
   );

   brc_axis_clip u_clip_y (
      .axis_in  (y_in),
      .axis_out (y_out)
   );

   always_comb begin
      vis     = (x_out.len > 0) && (y_out.len > 0);
      dst_x_w = sext_coord(x_out.dst_pos);
      dst_y_w = sext_coord(y_out.dst_pos);
      out_user_in = vis;
      out_data_in[79:64]  = dst_x_w[15:0];
      out_data_in[95:80]  = dst_y_w[15:0];
      if (vis) begin
         out_data_in[15:0]  = x_out.src_pos[15:0];
         out_data_in[31:16] = y_out.src_pos[15:0];
         out_data_in[47:32] = x_out.len[15:0];
         out_data_in[63:48] = y_out.len[15:0];
      end else begin
         // pass the raw source corner, zero size
         out_data_in[15:0]  = in_data_ff[15:0];
         out_data_in[31:16] = in_data_ff[31:16];
         out_data_in[47:32] = '0;
         out_data_in[63:48] = '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   a_hidden_zero_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata[47:32] == '0 && rsp_tdata[63:48] == '0))
      else $error("hidden result carries a nonzero size");

   a_visible_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[0]) |-> (rsp_tdata[47:32] != '0 && rsp_tdata[63:48] != '0))
      else $error("visible result carries a zero size");

   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted request not held in the input register");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !in_move) |=> (in_valid_ff && $stable(in_data_ff)))
      else $error("stalled request lost from the input register");

   a_move_fills: assert property (@(posedge clock) disable iff (reset)
      in_move |=> out_valid_ff)
      else $error("advanced request missing from the result register");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for blit_rect_clipper. Blit requests go in on the req
// stream and clipped rectangles are checked in order on the rsp stream
// against a behavioral clipper. The bench starts with hand-picked corner
// cases, then runs random traffic under several clip windows and three
// stall patterns.
// ----------------------------------------------------------------------------
module tb
   import brc_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic                         src_given;
      logic                         dst_given;
      logic signed [FIELD_BITS-1:0] src_x;
      logic signed [FIELD_BITS-1:0] src_y;
      logic [FIELD_BITS-1:0]        src_w;
      logic [FIELD_BITS-1:0]        src_h;
      logic [FIELD_BITS-1:0]        surf_w;
      logic [FIELD_BITS-1:0]        surf_h;
      logic signed [FIELD_BITS-1:0] dst_x;
      logic signed [FIELD_BITS-1:0] dst_y;
   } blit_req_type;

   typedef struct {
      logic                         visible;
      logic signed [FIELD_BITS-1:0] src_x;
      logic signed [FIELD_BITS-1:0] src_y;
      logic [FIELD_BITS-1:0]        w;
      logic [FIELD_BITS-1:0]        h;
      logic signed [FIELD_BITS-1:0] dst_x;
      logic signed [FIELD_BITS-1:0] dst_y;
   } blit_rsp_type;

   logic                      clock;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   // source_x, source_y, source_w, source_h, surface_width, surface_height,
   // dest_x, dest_y
   logic [REQ_DATA_BITS-1:0]  req_tdata  = '0;
   // source_rect_given, dest_given
   logic [REQ_USER_BITS-1:0]  req_tuser  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   // clipped_src_x, clipped_src_y, clipped_w, clipped_h, clipped_dst_x,
   // clipped_dst_y
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   // visible
   logic [RSP_USER_BITS-1:0]  rsp_tuser;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [FIELD_BITS-1:0]     csr_data   = '0;

   // clip window as the block should hold it
   logic signed [FIELD_BITS-1:0] clip_left_q   = '0;
   logic signed [FIELD_BITS-1:0] clip_top_q    = '0;
   logic [FIELD_BITS-1:0]        clip_width_q  = '0;
   logic [FIELD_BITS-1:0]        clip_height_q = '0;

   blit_rsp_type expected_clips[$];
   int           mismatch_count = 0;
   int           send_idle_pct  = 0;
   int           recv_idle_pct  = 0;

   blit_rect_clipper u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   // ---------------------------------------------------------------- clipper

   // wrap to the width of the destination position register
   function automatic longint wrap_dst(longint v);
      longint span;
      longint u;
      span = longint'(1) << COORD_BITS;
      u = v & (span - 1);
      return u[COORD_BITS-1] ? u - span : u;
   endfunction

   function automatic void clip_span(input bit given, input longint pos_in,
                                     input longint len_in, input longint surf,
                                     inout longint dpos, input longint edge_pos,
                                     input longint edge_len, output longint pos,
                                     output longint len);
      longint cut;
      if (given) begin
         pos = pos_in;
         len = len_in;
         // shift the destination by a negative source offset
         if (pos < 0) begin
            len  = len + pos;
            dpos = wrap_dst(dpos - pos);
            pos  = 0;
         end
         if (surf - pos < len) len = surf - pos;
      end else begin
         pos = 0;
         len = surf;
      end
      cut = edge_pos - dpos;
      if (cut > 0) begin
         len  = len - cut;
         dpos = wrap_dst(dpos + cut);
         pos  = pos + cut;
      end
      cut = dpos + len - edge_pos - edge_len;
      if (cut > 0) len = len - cut;
   endfunction

   function automatic blit_rsp_type predict_clip(blit_req_type r);
      longint       dx, dy, ox, oy, w, h;
      blit_rsp_type e;
      dx = r.dst_given ? wrap_dst(longint'(r.dst_x)) : 0;
      dy = r.dst_given ? wrap_dst(longint'(r.dst_y)) : 0;
      clip_span(r.src_given, longint'(r.src_x), longint'(r.src_w), longint'(r.surf_w),
                dx, longint'(clip_left_q), longint'(clip_width_q), ox, w);
      clip_span(r.src_given, longint'(r.src_y), longint'(r.src_h), longint'(r.surf_h),
                dy, longint'(clip_top_q), longint'(clip_height_q), oy, h);
      e.visible = (w > 0) && (h > 0);
      if (e.visible) begin
         e.src_x = ox[FIELD_BITS-1:0];
         e.src_y = oy[FIELD_BITS-1:0];
         e.w     = w[FIELD_BITS-1:0];
         e.h     = h[FIELD_BITS-1:0];
      end else begin
         e.src_x = r.src_x;
         e.src_y = r.src_y;
         e.w     = '0;
         e.h     = '0;
      end
      e.dst_x = dx[FIELD_BITS-1:0];
      e.dst_y = dy[FIELD_BITS-1:0];
      return e;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic blit_req_type make_blit(bit sg, bit dg, int sx, int sy, int sw,
                                              int sh, int fw, int fh, int dx, int dy);
      blit_req_type r;
      r.src_given = sg;
      r.dst_given = dg;
      r.src_x     = sx[FIELD_BITS-1:0];
      r.src_y     = sy[FIELD_BITS-1:0];
      r.src_w     = sw[FIELD_BITS-1:0];
      r.src_h     = sh[FIELD_BITS-1:0];
      r.surf_w    = fw[FIELD_BITS-1:0];
      r.surf_h    = fh[FIELD_BITS-1:0];
      r.dst_x     = dx[FIELD_BITS-1:0];
      r.dst_y     = dy[FIELD_BITS-1:0];
      return r;
   endfunction

   // coordinates: mostly a small area around the origin, sometimes extremes
   function automatic int pick_coord();
      unique case ($urandom_range(0, 15))
         0:       return -32768;
         1:       return 32767;
         2:       return 0;
         3:       return -1;
         4, 5:    return int'($urandom_range(0, 65535));
         default: return int'($urandom_range(0, 400)) - 100;
      endcase
   endfunction

   function automatic int pick_size();
      unique case ($urandom_range(0, 15))
         0:       return 0;
         1:       return 65535;
         2:       return 1;
         3, 4:    return int'($urandom_range(0, 65535));
         default: return int'($urandom_range(0, 400));
      endcase
   endfunction

   function automatic blit_req_type random_blit();
      return make_blit($urandom_range(0, 3) != 0, $urandom_range(0, 3) != 0,
                       pick_coord(), pick_coord(), pick_size(), pick_size(),
                       pick_size(), pick_size(), pick_coord(), pick_coord());
   endfunction

   task automatic send_blit(blit_req_type r);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= {r.dst_given, r.src_given};
      req_tdata  <= {r.dst_y, r.dst_x, r.surf_h, r.surf_w, r.src_h, r.src_w,
                     r.src_y, r.src_x};
      do @(posedge clock); while (!req_tready);
      expected_clips = {expected_clips, predict_clip(r)};
   endtask

   // hold the request side until every result word is back
   task automatic settle();
      req_tvalid <= 1'b0;
      while (expected_clips.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_csr(brc_reg_type idx, int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[FIELD_BITS-1:0];
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_clip_window(int left, int top, int width, int height);
      put_csr(REG_CLIP_LEFT, left);
      put_csr(REG_CLIP_TOP, top);
      put_csr(REG_CLIP_WIDTH, width);
      put_csr(REG_CLIP_HEIGHT, height);
      csr_valid     <= 1'b0;
      clip_left_q   = left[FIELD_BITS-1:0];
      clip_top_q    = top[FIELD_BITS-1:0];
      clip_width_q  = width[FIELD_BITS-1:0];
      clip_height_q = height[FIELD_BITS-1:0];
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   function automatic void check_field(string field, longint want, longint got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      blit_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_clips.size() == 0) begin
            $error("result word with no request pending");
            mismatch_count++;
         end else begin
            want = expected_clips.pop_front();
            check_field("visible", want.visible, rsp_tuser[0]);
            check_field("clipped_src_x", want.src_x,
                        longint'($signed(rsp_tdata[0*FIELD_BITS +: FIELD_BITS])));
            check_field("clipped_src_y", want.src_y,
                        longint'($signed(rsp_tdata[1*FIELD_BITS +: FIELD_BITS])));
            check_field("clipped_w", want.w, rsp_tdata[2*FIELD_BITS +: FIELD_BITS]);
            check_field("clipped_h", want.h, rsp_tdata[3*FIELD_BITS +: FIELD_BITS]);
            check_field("clipped_dst_x", want.dst_x,
                        longint'($signed(rsp_tdata[4*FIELD_BITS +: FIELD_BITS])));
            check_field("clipped_dst_y", want.dst_y,
                        longint'($signed(rsp_tdata[5*FIELD_BITS +: FIELD_BITS])));
         end
      end
   end

   // ---------------------------------------------------------------- tests

   // clip window is empty out of reset, so nothing may be visible
   task automatic test_reset_window();
      send_blit(make_blit(1, 1, 0, 0, 10, 10, 20, 20, 5, 5));
      send_blit(make_blit(0, 0, 0, 0, 0, 0, 640, 480, 0, 0));
   endtask

   task automatic test_corner_cases();
      settle();
      set_clip_window(10, 20, 100, 80);
      send_blit(make_blit(0, 0, 0, 0, 0, 0, 50, 50, 0, 0));
      send_blit(make_blit(1, 1, -5, -7, 30, 30, 20, 20, 15, 25));
      send_blit(make_blit(1, 1, 0, 0, 40, 40, 40, 40, 200, 200));
      send_blit(make_blit(1, 1, 5, 5, 60, 60, 100, 100, 90, 90));
      send_blit(make_blit(1, 0, 3, 4, 10, 10, 20, 20, 77, 77));
      send_blit(make_blit(0, 1, 123, -45, 9, 9, 30, 30, 40, 50));
      send_blit(make_blit(1, 1, 0, 0, 0, 10, 20, 20, 20, 30));
      send_blit(make_blit(1, 1, 0, 0, 10, 10, 0, 0, 20, 30));
      send_blit(make_blit(1, 1, 50, 50, 10, 10, 20, 20, 20, 30));
      send_blit(make_blit(1, 1, -32768, 32767, 65535, 65535, 65535, 65535, -32768, 32767));
      send_blit(make_blit(1, 1, -1, -1, 65535, 65535, 65535, 65535, -1, -1));
      send_blit(make_blit(1, 1, -32768, -32768, 65535, 65535, 65535, 65535, 32767, 32767));
      settle();
      set_clip_window(-32768, -32768, 65535, 65535);
      send_blit(make_blit(0, 0, 0, 0, 0, 0, 65535, 65535, 0, 0));
      send_blit(make_blit(1, 1, -32768, -32768, 65535, 65535, 65535, 65535, 32767, 32767));
      send_blit(make_blit(1, 1, 0, 0, 65535, 65535, 65535, 65535, -32768, -32768));
      settle();
      set_clip_window(32767, 32767, 1, 1);
      send_blit(make_blit(1, 1, 0, 0, 10, 10, 20, 20, 32767, 32767));
      send_blit(make_blit(1, 1, 0, 0, 10, 10, 20, 20, 32760, 32760));
      send_blit(make_blit(0, 1, 0, 0, 0, 0, 65535, 65535, 32767, 32767));
   endtask

   // new clip window every block of requests; each change drains the pipe
   task automatic test_random_traffic(int count, int s_idle, int r_idle);
      int i;
      send_idle_pct = s_idle;
      recv_idle_pct = r_idle;
      for (i = 0; i < count; i++) begin
         if (i % 120 == 0) begin
            settle();
            set_clip_window(pick_coord(), pick_coord(), pick_size(), pick_size());
         end
         send_blit(random_blit());
      end
   endtask

   initial begin
      send_idle_pct = 12;
      recv_idle_pct = 77;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_window();
      test_corner_cases();
      test_random_traffic(630, 12, 77);
      test_random_traffic(630, 77, 12);
      test_random_traffic(630, 0, 0);
      settle();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
